### rtl/vpws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpws_pkg
// shared types, constants and codes of the particle wall step block
// ----------------------------------------------------------------------------
package vpws_pkg;

    localparam int MAX_WALLS_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int REST_BITS     = 16;

    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_BOTTOM = 3'd1;
    localparam logic [2:0] SIDE_LEFT   = 3'd2;
    localparam logic [2:0] SIDE_RIGHT  = 3'd3;
    localparam logic [2:0] SIDE_TOP    = 3'd4;

    localparam logic [2:0] REG_TIME_STEP  = 3'd0;
    localparam logic [2:0] REG_STEP_SQ    = 3'd1;
    localparam logic [2:0] REG_HALF_INV   = 3'd2;
    localparam logic [2:0] REG_GRAV_ON    = 3'd3;
    localparam logic [2:0] REG_GRAV_ACC   = 3'd4;
    localparam logic [2:0] REG_PERP_REST  = 3'd5;
    localparam logic [2:0] REG_PAR_REST   = 3'd6;
    localparam logic [2:0] REG_EDGE_OFF   = 3'd7;

    typedef struct packed {
        logic               func;
        logic [2:0]         wall_slot;
        logic               wall_valid;
        logic signed [31:0] coord_ax;
        logic signed [31:0] coord_ay;
        logic signed [31:0] coord_bx;
        logic signed [31:0] coord_by;
        logic signed [31:0] drag_accel_x;
        logic signed [31:0] drag_accel_y;
        logic               is_pinned;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_prior_x;
        logic signed [31:0] new_prior_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [2:0]         last_hit_side;
    } t_out_item;

    typedef struct packed {
        logic [16:0] time_step;
        logic [16:0] time_step_sq;
        logic [30:0] half_inv;
        logic        grav_on;
        logic [30:0] grav_acc;
        logic [16:0] perp_rest;
        logic [16:0] par_rest;
        logic [15:0] edge_off;
    } t_cfg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_PASS  = 4'd2,
        OP_ACC   = 4'd3,
        OP_NEXT  = 4'd4,
        OP_VEL   = 4'd5,
        OP_WALL  = 4'd6,
        OP_SCALE = 4'd7,
        OP_PRIOR = 4'd8,
        OP_PRIOR2= 4'd9
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic wall_on;
    } t_status;

endpackage
`default_nettype wire

### rtl/verlet_particle_wall_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// verlet_particle_wall_step
// one position verlet step of a 2d particle against a table of wall boxes
//
// input channel: a request with func 0 writes one wall entry (no result);
// func 1 steps the particle and gives one result request.
// config channel: index and data, always ready; it is to be written only
// while idle, which the block itself does not enforce. a step: accept,
// integration (one shared 34x34 multiplier, x then y), one test per wall
// slot, a bounce per hit; a pinned particle skips these. the result is
// held until taken, and no new request is taken until it leaves, so a
// stalled receiver holds the whole block. reset clears the wall table's
// active bits and loads the default register values.
// ----------------------------------------------------------------------------
module verlet_particle_wall_step #(
    parameter int MAX_WALLS = vpws_pkg::MAX_WALLS_DEF,
    parameter int FRAC_BITS = vpws_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  vpws_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output vpws_pkg::t_out_item  o_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);
    import vpws_pkg::*;

    localparam int IW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

    t_cfg          r_cfg;
    t_cmd          cmd;
    t_status       status;
    logic [IW-1:0] wall_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step    <= 17'd655;
            r_cfg.time_step_sq <= 17'd7;
            r_cfg.half_inv     <= 31'd3276800;
            r_cfg.grav_on      <= 1'b1;
            r_cfg.grav_acc     <= 31'd642908;
            r_cfg.perp_rest    <= 17'd52429;
            r_cfg.par_rest     <= 17'd64225;
            r_cfg.edge_off     <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIME_STEP: r_cfg.time_step    <= i_cfg_data[16:0];
                REG_STEP_SQ:   r_cfg.time_step_sq <= i_cfg_data[16:0];
                REG_HALF_INV:  r_cfg.half_inv     <= i_cfg_data[30:0];
                REG_GRAV_ON:   r_cfg.grav_on      <= i_cfg_data[0];
                REG_GRAV_ACC:  r_cfg.grav_acc     <= i_cfg_data[30:0];
                REG_PERP_REST: r_cfg.perp_rest    <= i_cfg_data[16:0];
                REG_PAR_REST:  r_cfg.par_rest     <= i_cfg_data[16:0];
                REG_EDGE_OFF:  r_cfg.edge_off     <= i_cfg_data[15:0];
                default:       r_cfg              <= r_cfg;
            endcase
        end
    end

    vpws_ctrl #(.MAX_WALLS(MAX_WALLS), .IW(IW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_data.func),
        .i_pinned   (i_data.is_pinned),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_wall_idx (wall_idx),
        .o_valid    (o_valid),
        .i_ready    (i_ready)
    );

    vpws_datapath #(.MAX_WALLS(MAX_WALLS), .FRAC_BITS(FRAC_BITS), .IW(IW)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_data),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_wall_idx (wall_idx),
        .o_status   (status),
        .o_result   (o_data)
    );

endmodule
`default_nettype wire

### rtl/vpws_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpws_datapath
// wall table, particle registers and one shared 34x34 multiplier
// ----------------------------------------------------------------------------
module vpws_datapath #(
    parameter int MAX_WALLS = 8,
    parameter int FRAC_BITS = 16,
    parameter int IW        = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  vpws_pkg::t_in_item       i_item,
    input  vpws_pkg::t_cfg           i_cfg,
    input  vpws_pkg::t_cmd           i_cmd,
    input  wire  [IW-1:0]            i_wall_idx,
    output vpws_pkg::t_status        o_status,
    output vpws_pkg::t_out_item      o_result
);
    import vpws_pkg::*;

    logic                 r_active [MAX_WALLS];
    logic signed [31:0]   r_left   [MAX_WALLS];
    logic signed [31:0]   r_right  [MAX_WALLS];
    logic signed [31:0]   r_bottom [MAX_WALLS];
    logic signed [31:0]   r_top    [MAX_WALLS];

    logic signed [31:0] r_ax, r_ay, r_bx, r_by, r_dx, r_dy;
    logic signed [31:0] r_px, r_py, r_qx, r_qy, r_vx, r_vy;
    logic [2:0]         r_side, r_hit;
    logic               r_step; // sub-phase: 0 = x, 1 = y

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic signed [31:0] mul_q_frac, mul_q_rest;
    logic signed [31:0] dpx, dpy;

    assign mul_p      = mul_a * mul_b;
    assign mul_q_frac = 32'(mul_p >>> FRAC_BITS);
    assign mul_q_rest = 32'(mul_p >>> REST_BITS);

    // displacement over the step, wrapped to 32 bits
    assign dpx = r_px - r_ax;
    assign dpy = r_py - r_ay;

    logic signed [31:0] w_l, w_r, w_b, w_t, off;
    logic [2:0]         hit_side;
    logic               is_perp;

    assign w_l = r_left[i_wall_idx];
    assign w_r = r_right[i_wall_idx];
    assign w_b = r_bottom[i_wall_idx];
    assign w_t = r_top[i_wall_idx];
    assign off = {16'd0, i_cfg.edge_off};

    always_comb begin
        if (r_ay <= w_b && r_py >= w_b && r_ax >= w_l && r_ax <= w_r) begin
            hit_side = SIDE_BOTTOM;
        end else if (r_ax <= w_l && r_px >= w_l && r_ay <= w_t && r_ay >= w_b) begin
            hit_side = SIDE_LEFT;
        end else if (r_ax >= w_r && r_px <= w_r && r_ay <= w_t && r_ay >= w_b) begin
            hit_side = SIDE_RIGHT;
        end else if (r_ay >= w_t && r_py <= w_t && r_ax >= w_l && r_ax <= w_r) begin
            hit_side = SIDE_TOP;
        end else begin
            hit_side = SIDE_NONE;
        end
    end

    assign is_perp = (r_hit == SIDE_BOTTOM) || (r_hit == SIDE_TOP);
    assign o_status.hit     = (hit_side != SIDE_NONE);
    assign o_status.wall_on = r_active[i_wall_idx];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_NEXT: begin
                mul_a = {17'd0, i_cfg.time_step_sq};
                mul_b = r_step ? 34'(r_dy) : 34'(r_dx);
            end
            OP_VEL: begin
                mul_a = {3'd0, i_cfg.half_inv};
                mul_b = r_step ? 34'(dpy) : 34'(dpx);
            end
            OP_SCALE: begin
                mul_a = (is_perp ^ r_step) ? {17'd0, i_cfg.par_rest}
                                           : {17'd0, i_cfg.perp_rest};
                mul_b = r_step ? 34'(r_vy) : 34'(r_vx);
            end
            OP_PRIOR, OP_PRIOR2: begin
                mul_a = {17'd0, i_cfg.time_step};
                mul_b = (i_cmd.op == OP_PRIOR2) ? 34'(r_vy) : 34'(r_vx);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WALLS; k++) begin
                r_active[k] <= 1'b0;
            end
        end else if (i_cmd.start && i_cmd.op == OP_LOAD
                     && 32'(i_item.wall_slot) < MAX_WALLS) begin
            r_active[IW'(i_item.wall_slot)] <= i_item.wall_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_cmd.op == OP_LOAD
            && 32'(i_item.wall_slot) < MAX_WALLS) begin
            r_left[IW'(i_item.wall_slot)]   <= i_item.coord_ax;
            r_bottom[IW'(i_item.wall_slot)] <= i_item.coord_ay;
            r_right[IW'(i_item.wall_slot)]  <= i_item.coord_bx;
            r_top[IW'(i_item.wall_slot)]    <= i_item.coord_by;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_PASS: begin
                r_px <= i_item.coord_ax; r_py <= i_item.coord_ay;
                r_qx <= i_item.coord_bx; r_qy <= i_item.coord_by;
                r_vx <= '0; r_vy <= '0; r_side <= SIDE_NONE;
            end
            OP_ACC: begin
                r_ax <= i_item.coord_ax; r_ay <= i_item.coord_ay;
                r_bx <= i_item.coord_bx; r_by <= i_item.coord_by;
                r_dx <= i_item.drag_accel_x;
                r_dy <= i_cfg.grav_on ? i_item.drag_accel_y - {1'b0, i_cfg.grav_acc}
                                      : i_item.drag_accel_y;
                r_qx <= i_item.coord_ax; r_qy <= i_item.coord_ay;
                r_side <= SIDE_NONE;
                r_step <= 1'b0;
            end
            OP_NEXT: begin
                if (r_step) begin
                    r_py <= (r_ay <<< 1) - r_by + mul_q_frac;
                end else begin
                    r_px <= (r_ax <<< 1) - r_bx + mul_q_frac;
                end
                r_step <= ~r_step;
            end
            OP_VEL: begin
                if (r_step) begin
                    r_vy <= mul_q_frac;
                end else begin
                    r_vx <= mul_q_frac;
                end
                r_step <= ~r_step;
            end
            OP_WALL: begin
                r_hit  <= hit_side;
                r_step <= 1'b0;
                unique case (hit_side)
                    SIDE_BOTTOM: r_py <= w_b - off;
                    SIDE_LEFT:   r_px <= w_l - off;
                    SIDE_RIGHT:  r_px <= w_r + off;
                    SIDE_TOP:    r_py <= w_t + off;
                    default:     r_side <= r_side;
                endcase
                if (hit_side != SIDE_NONE) begin
                    r_side <= hit_side;
                end
            end
            OP_SCALE: begin
                if (r_step) begin
                    r_vy <= is_perp ? -mul_q_rest : mul_q_rest;
                end else begin
                    r_vx <= is_perp ? mul_q_rest : -mul_q_rest;
                end
                r_step <= ~r_step;
            end
            OP_PRIOR:  r_qx <= r_px - mul_q_frac;
            OP_PRIOR2: r_qy <= r_py - mul_q_frac;
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_result.new_pos_x     = r_px;
    assign o_result.new_pos_y     = r_py;
    assign o_result.new_prior_x   = r_qx;
    assign o_result.new_prior_y   = r_qy;
    assign o_result.vel_x         = r_vx;
    assign o_result.vel_y         = r_vy;
    assign o_result.last_hit_side = r_side;

endmodule
`default_nettype wire

### rtl/vpws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpws_ctrl
// sequencer: wall load, integration, wall walk, bounce handling and result hand-off
// ----------------------------------------------------------------------------
module vpws_ctrl #(
    parameter int MAX_WALLS = 8,
    parameter int IW        = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_func,
    input  wire                i_pinned,
    input  vpws_pkg::t_status  i_status,
    output vpws_pkg::t_cmd     o_cmd,
    output logic [IW-1:0]      o_wall_idx,
    output logic               o_valid,
    input  wire                i_ready
);
    import vpws_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_NEXT  = 9'b000000010,
        S_VEL   = 9'b000000100,
        S_WALL  = 9'b000001000,
        S_SCALE = 9'b000010000,
        S_PRX   = 9'b000100000,
        S_PRY   = 9'b001000000,
        S_ADV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_half, n_half;
    logic          last_wall;

    assign last_wall  = (32'(r_idx) == MAX_WALLS - 1);
    assign o_wall_idx = r_idx;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_half    = r_half;
        o_cmd.op    = OP_IDLE;
        o_cmd.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx  = '0;
                    n_half = 1'b0;
                    if (!i_func) begin
                        o_cmd.op = OP_LOAD;
                    end else if (i_pinned) begin
                        o_cmd.op = OP_PASS;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.op = OP_ACC;
                        n_state  = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                o_cmd.op = OP_NEXT;
                n_half   = ~r_half;
                if (r_half) n_state = S_VEL;
            end
            S_VEL: begin
                o_cmd.op = OP_VEL;
                n_half   = ~r_half;
                if (r_half) n_state = S_WALL;
            end
            S_WALL: begin
                o_cmd.op = OP_WALL;
                n_half   = 1'b0;
                if (i_status.wall_on && i_status.hit) begin
                    n_state = S_SCALE;
                end else if (last_wall) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_half   = ~r_half;
                if (r_half) n_state = S_PRX;
            end
            S_PRX: begin
                o_cmd.op = OP_PRIOR;
                n_state  = S_PRY;
            end
            S_PRY: begin
                o_cmd.op = OP_PRIOR2;
                n_state  = S_ADV;
            end
            S_ADV: begin
                if (last_wall) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WALL;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // an inactive wall must not disturb the datapath
        if (r_state == S_WALL && !i_status.wall_on) o_cmd.op = OP_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_half  <= n_half;
        end
    end

endmodule
`default_nettype wire
